// ===== hw/rtl/wpw_pkg.sv =====
// Shared types and constants for the window pixel writer.
// Holds opcode and result-kind codes, frame limits and inter-module structs.
// No dependencies.
package wpw_pkg;

	localparam int DIM_W           = 13;
	localparam int COORD_W         = 12;
	localparam int WIN_W           = 16;
	localparam int RGB_W           = 24;
	localparam int ARGB_W          = 32;
	localparam int MAX_DIM_DEFAULT = 4096;

	localparam logic [DIM_W-1:0]  MIN_WIDTH      = 13'd160;
	localparam logic [DIM_W-1:0]  MIN_HEIGHT     = 13'd120;
	localparam logic [DIM_W-1:0]  RESET_WIDTH    = 13'd480;
	localparam logic [DIM_W-1:0]  RESET_HEIGHT   = 13'd272;
	localparam logic [7:0]        OPAQUE_ALPHA   = 8'hFF;

	typedef enum logic [1:0] {
		REG_FRAME_WIDTH  = 2'd0,
		REG_FRAME_HEIGHT = 2'd1
	} reg_idx_t;

	// The last opcode is unused: it gives no result and changes no state.
	typedef enum logic [1:0] {
		OP_SET_WINDOW = 2'd0,
		OP_PUSH_PIXEL = 2'd1,
		OP_FLUSH      = 2'd2,
		OP_RESERVED   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		KIND_WINDOW_SET    = 3'd0,
		KIND_PIXEL_WRITTEN = 3'd1,
		KIND_PIXEL_DROPPED = 3'd2,
		KIND_DIRTY_RECT    = 3'd3,
		KIND_NOTHING_DIRTY = 3'd4
	} kind_t;

	// Frame size as seen by the datapath, plus a pulse on a real size change.
	typedef struct packed {
		logic [DIM_W-1:0] width;
		logic [DIM_W-1:0] height;
		logic             changed;
	} frame_t;

	// Frame position of the current pixel and whether it lands in the frame.
	typedef struct packed {
		logic               in_frame;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
	} pix_pos_t;

	// Dirty bounding box, inclusive bounds.
	typedef struct packed {
		logic               valid;
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] top;
		logic [COORD_W-1:0] right;
		logic [COORD_W-1:0] bottom;
	} rect_t;

endpackage

// ===== hw/rtl/window_pixel_writer_dirty_rect.sv =====
// Address-window pixel writer with dirty rectangle tracking.
// Requests pass the input register, then the result register; a result-side stall holds them between.
// Throughput: one request per cycle unless the result side stalls; window, counter and dirty-box state update on fire.
// Reset: async active low; frame 480x272, window origin 0, span 65536, counters 0, nothing dirty.
// Opcode 3 passes through the input register and yields no result.
module window_pixel_writer_dirty_rect import wpw_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write port
	input  logic               write_en,
	input  logic [1:0]         write_index,
	input  logic [DIM_W-1:0]   write_data,
	// request channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         opcode,
	input  logic [WIN_W-1:0]   window_left,
	input  logic [WIN_W-1:0]   window_top,
	input  logic [WIN_W-1:0]   window_right,
	input  logic [RGB_W-1:0]   pixel_rgb,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         kind,
	output logic [COORD_W-1:0] write_x,
	output logic [COORD_W-1:0] write_y,
	output logic [ARGB_W-1:0]  write_argb,
	output logic [COORD_W-1:0] rect_left,
	output logic [COORD_W-1:0] rect_top,
	output logic [COORD_W-1:0] rect_right,
	output logic [COORD_W-1:0] rect_bottom
);

	// input register
	logic               valid_s1;
	logic [1:0]         op_s1;
	logic [WIN_W-1:0]   left_s1;
	logic [WIN_W-1:0]   top_s1;
	logic [WIN_W-1:0]   right_s1;
	logic [RGB_W-1:0]   rgb_s1;

	// result register
	logic               out_valid_q;
	logic [2:0]         kind_q;
	logic [COORD_W-1:0] wx_q;
	logic [COORD_W-1:0] wy_q;
	logic [ARGB_W-1:0]  argb_q;
	logic [COORD_W-1:0] rl_q;
	logic [COORD_W-1:0] rt_q;
	logic [COORD_W-1:0] rr_q;
	logic [COORD_W-1:0] rb_q;

	// next result
	logic [2:0]         kind_d;
	logic [COORD_W-1:0] wx_d;
	logic [COORD_W-1:0] wy_d;
	logic [ARGB_W-1:0]  argb_d;
	logic [COORD_W-1:0] rl_d;
	logic [COORD_W-1:0] rt_d;
	logic [COORD_W-1:0] rr_d;
	logic [COORD_W-1:0] rb_d;

	logic     advance;
	logic     fire;
	logic     accept;
	frame_t   frame;
	pix_pos_t pos;
	rect_t    rect;

	// The result register frees up when empty or when its result is taken this cycle.
	assign advance  = !out_valid_q || !out_stall;
	assign fire     = valid_s1 && advance;
	// Stall only when the input register holds a request that cannot move on.
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	wpw_frame_cfg #(
		.MAX_DIM (MAX_DIM)
	) u_cfg (
		.clk         (clk),
		.arst_n      (arst_n),
		.write_en    (write_en),
		.write_index (write_index),
		.write_data  (write_data),
		.frame       (frame)
	);

	wpw_window_ctrl u_win (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.op     (op_s1),
		.left   (left_s1),
		.top    (top_s1),
		.right  (right_s1),
		.frame  (frame),
		.pos    (pos)
	);

	wpw_dirty_box u_dirty (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.op     (op_s1),
		.pos    (pos),
		.clear  (frame.changed),
		.rect   (rect)
	);

	// Advance the input register; hold it while the result side is blocked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1    <= opcode;
			left_s1  <= window_left;
			top_s1   <= window_top;
			right_s1 <= window_right;
			rgb_s1   <= pixel_rgb;
		end
	end

	// Load a result for every defined opcode; drop the reserved one silently.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= fire && (op_s1 != OP_RESERVED);
		end
	end

	// Build the result; fields that do not apply stay zero.
	always_comb begin
		kind_d = KIND_WINDOW_SET;
		wx_d   = '0;
		wy_d   = '0;
		argb_d = '0;
		rl_d   = '0;
		rt_d   = '0;
		rr_d   = '0;
		rb_d   = '0;
		case (op_s1)
			OP_PUSH_PIXEL: begin
				if (pos.in_frame) begin
					kind_d = KIND_PIXEL_WRITTEN;
					wx_d   = pos.x;
					wy_d   = pos.y;
					argb_d = {OPAQUE_ALPHA, rgb_s1};
				end else begin
					kind_d = KIND_PIXEL_DROPPED;
				end
			end
			OP_FLUSH: begin
				if (rect.valid) begin
					kind_d = KIND_DIRTY_RECT;
					rl_d   = rect.left;
					rt_d   = rect.top;
					rr_d   = rect.right;
					rb_d   = rect.bottom;
				end else begin
					kind_d = KIND_NOTHING_DIRTY;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			kind_q <= kind_d;
			wx_q   <= wx_d;
			wy_q   <= wy_d;
			argb_q <= argb_d;
			rl_q   <= rl_d;
			rt_q   <= rt_d;
			rr_q   <= rr_d;
			rb_q   <= rb_d;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign write_x     = wx_q;
	assign write_y     = wy_q;
	assign write_argb  = argb_q;
	assign rect_left   = rl_q;
	assign rect_top    = rt_q;
	assign rect_right  = rr_q;
	assign rect_bottom = rb_q;

	// A stall back to the source always comes from a held input register.
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("in_stall raised with an empty input register");

	// A blocked input register keeps its request.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(op_s1))
		else $error("input register lost a blocked request");

	// A flush always leaves the dirty box empty.
	a_flush_clears: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (op_s1 == OP_FLUSH) |=> !rect.valid)
		else $error("dirty box still valid after flush");

	// A written pixel always marks the box dirty unless the frame size changed.
	a_write_dirties: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (op_s1 == OP_PUSH_PIXEL) && pos.in_frame && !frame.changed |=> rect.valid)
		else $error("written pixel did not mark the dirty box");

endmodule

// ===== hw/rtl/wpw_frame_cfg.sv =====
// Frame size registers with clamping on write.
// Depends on wpw_pkg.
module wpw_frame_cfg import wpw_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             write_en,
	input  logic [1:0]       write_index,
	input  logic [DIM_W-1:0] write_data,
	output frame_t           frame
);

	localparam logic [DIM_W-1:0] MAX_V = DIM_W'(MAX_DIM);

	logic [DIM_W-1:0] width_q;
	logic [DIM_W-1:0] height_q;
	logic [DIM_W-1:0] width_new;
	logic [DIM_W-1:0] height_new;
	logic             width_wr;
	logic             height_wr;

	always_comb begin
		width_new = write_data;
		if (write_data < MIN_WIDTH) begin
			width_new = MIN_WIDTH;
		end else if (write_data > MAX_V) begin
			width_new = MAX_V;
		end
		height_new = write_data;
		if (write_data < MIN_HEIGHT) begin
			height_new = MIN_HEIGHT;
		end else if (write_data > MAX_V) begin
			height_new = MAX_V;
		end
		width_wr  = write_en && (write_index == REG_FRAME_WIDTH)  && (width_new != width_q);
		height_wr = write_en && (write_index == REG_FRAME_HEIGHT) && (height_new != height_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RESET_WIDTH;
			height_q <= RESET_HEIGHT;
		end else begin
			if (width_wr) begin
				width_q <= width_new;
			end
			if (height_wr) begin
				height_q <= height_new;
			end
		end
	end

	assign frame.width   = width_q;
	assign frame.height  = height_q;
	assign frame.changed = width_wr || height_wr;

endmodule

// ===== hw/rtl/wpw_window_ctrl.sv =====
// Address window state: origin, span and column/row counters.
// Resolves the frame position of each pixel. Depends on wpw_pkg.
module wpw_window_ctrl import wpw_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  logic [1:0]       op,
	input  logic [WIN_W-1:0] left,
	input  logic [WIN_W-1:0] top,
	input  logic [WIN_W-1:0] right,
	input  frame_t           frame,
	output pix_pos_t         pos
);

	logic [WIN_W-1:0] origin_x_q;
	logic [WIN_W-1:0] origin_y_q;
	logic [WIN_W-1:0] span_q;
	logic [WIN_W-1:0] col_q;
	logic [WIN_W-1:0] row_q;
	logic [WIN_W:0]   x;
	logic [WIN_W:0]   y;
	logic [WIN_W:0]   col_next;
	logic [WIN_W:0]   limit;

	always_comb begin
		x        = {1'b0, origin_x_q} + {1'b0, col_q};
		y        = {1'b0, origin_y_q} + {1'b0, row_q};
		col_next = {1'b0, col_q} + 17'd1;
		// a zero span stands for the full 65536 columns
		limit    = (span_q == '0) ? {1'b1, {WIN_W{1'b0}}} : {1'b0, span_q};
		pos.in_frame = (x < {4'b0, frame.width}) && (y < {4'b0, frame.height});
		pos.x        = x[COORD_W-1:0];
		pos.y        = y[COORD_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			span_q     <= '0;
			col_q      <= '0;
			row_q      <= '0;
		end else if (fire) begin
			case (op)
				OP_SET_WINDOW: begin
					origin_x_q <= left;
					origin_y_q <= top;
					span_q     <= right - left + 16'd1;
					col_q      <= '0;
					row_q      <= '0;
				end
				OP_PUSH_PIXEL: begin
					if (col_next >= limit) begin
						col_q <= '0;
						if (row_q != {WIN_W{1'b1}}) begin
							row_q <= row_q + 16'd1;
						end
					end else begin
						col_q <= col_next[WIN_W-1:0];
					end
				end
				OP_FLUSH: begin
					col_q <= '0;
					row_q <= '0;
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== hw/rtl/wpw_dirty_box.sv =====
// Dirty bounding box tracker: grows on written pixels, clears on flush
// and on a frame size change. Depends on wpw_pkg.
module wpw_dirty_box import wpw_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     fire,
	input  logic [1:0] op,
	input  pix_pos_t pos,
	input  logic     clear,
	output rect_t    rect
);

	rect_t box_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q <= '0;
		end else if (clear) begin
			box_q.valid <= 1'b0;
		end else if (fire && (op == OP_FLUSH)) begin
			box_q.valid <= 1'b0;
		end else if (fire && (op == OP_PUSH_PIXEL) && pos.in_frame) begin
			box_q.valid <= 1'b1;
			if (!box_q.valid) begin
				box_q.left   <= pos.x;
				box_q.right  <= pos.x;
				box_q.top    <= pos.y;
				box_q.bottom <= pos.y;
			end else begin
				if (pos.x < box_q.left) begin
					box_q.left <= pos.x;
				end
				if (pos.x > box_q.right) begin
					box_q.right <= pos.x;
				end
				if (pos.y < box_q.top) begin
					box_q.top <= pos.y;
				end
				if (pos.y > box_q.bottom) begin
					box_q.bottom <= pos.y;
				end
			end
		end
	end

	assign rect = box_q;

endmodule

// ===== bench/wpw_watch.sv =====
// Result watcher for the window pixel writer: tracks register writes and requests,
// predicts every result and compares it with what the block delivers.
// Depends on wpw_pkg for opcode, kind and register codes and the field widths.
module wpw_watch import wpw_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEFAULT
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               write_en,
	input  logic [1:0]         write_index,
	input  logic [DIM_W-1:0]   write_data,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic [1:0]         opcode,
	input  logic [WIN_W-1:0]   window_left,
	input  logic [WIN_W-1:0]   window_top,
	input  logic [WIN_W-1:0]   window_right,
	input  logic [RGB_W-1:0]   pixel_rgb,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [2:0]         kind,
	input  logic [COORD_W-1:0] write_x,
	input  logic [COORD_W-1:0] write_y,
	input  logic [ARGB_W-1:0]  write_argb,
	input  logic [COORD_W-1:0] rect_left,
	input  logic [COORD_W-1:0] rect_top,
	input  logic [COORD_W-1:0] rect_right,
	input  logic [COORD_W-1:0] rect_bottom,
	output int                 failures,
	output int                 pending
);

	typedef struct packed {
		kind_t              k;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [ARGB_W-1:0]  argb;
		logic [COORD_W-1:0] left;
		logic [COORD_W-1:0] top;
		logic [COORD_W-1:0] right;
		logic [COORD_W-1:0] bottom;
	} writer_result_t;

	writer_result_t results_due[$];

	// shadow of the writer state
	logic [DIM_W-1:0]   frame_w, frame_h;
	logic [WIN_W-1:0]   org_x, org_y, span, col_cnt, row_cnt;
	logic               dirty;
	logic [COORD_W-1:0] box_l, box_t, box_r, box_b;

	task automatic flag_mismatch(input string msg);
		failures++;
		$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want);
		if (got !== want)
			flag_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
	endtask

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [DIM_W-1:0] lo);
		if (v < lo)
			return lo;
		if (v > MAX_DIM)
			return DIM_W'(MAX_DIM);
		return v;
	endfunction

	// Apply one register write; a real size change drops the dirty box.
	task automatic take_register(input logic [1:0] idx, input logic [DIM_W-1:0] data);
		logic [DIM_W-1:0] v;
		case (idx)
			REG_FRAME_WIDTH: begin
				v = clamp_dim(data, MIN_WIDTH);
				if (v != frame_w) begin
					frame_w = v;
					dirty = 1'b0;
				end
			end
			REG_FRAME_HEIGHT: begin
				v = clamp_dim(data, MIN_HEIGHT);
				if (v != frame_h) begin
					frame_h = v;
					dirty = 1'b0;
				end
			end
			default: ;
		endcase
	endtask

	// Advance the writer by one request and queue the result it produces.
	task automatic advance_writer(input logic [1:0] op, input logic [WIN_W-1:0] l,
			input logic [WIN_W-1:0] t, input logic [WIN_W-1:0] r, input logic [RGB_W-1:0] rgb);
		writer_result_t res;
		logic [16:0] px, py, lim, nxt;
		res = '0;
		case (op)
			OP_SET_WINDOW: begin
				org_x = l;
				org_y = t;
				span = r - l + 16'd1;
				col_cnt = '0;
				row_cnt = '0;
				res.k = KIND_WINDOW_SET;
				results_due.push_back(res);
			end
			OP_PUSH_PIXEL: begin
				px = {1'b0, org_x} + {1'b0, col_cnt};
				py = {1'b0, org_y} + {1'b0, row_cnt};
				lim = (span == '0) ? 17'h10000 : {1'b0, span};
				if (px < frame_w && py < frame_h) begin
					res.k = KIND_PIXEL_WRITTEN;
					res.x = px[COORD_W-1:0];
					res.y = py[COORD_W-1:0];
					res.argb = {OPAQUE_ALPHA, rgb};
					if (!dirty) begin
						box_l = res.x;
						box_r = res.x;
						box_t = res.y;
						box_b = res.y;
						dirty = 1'b1;
					end else begin
						if (res.x < box_l) box_l = res.x;
						if (res.x > box_r) box_r = res.x;
						if (res.y < box_t) box_t = res.y;
						if (res.y > box_b) box_b = res.y;
					end
				end else begin
					res.k = KIND_PIXEL_DROPPED;
				end
				nxt = {1'b0, col_cnt} + 17'd1;
				if (nxt >= lim) begin
					col_cnt = '0;
					if (row_cnt != 16'hFFFF)
						row_cnt = row_cnt + 16'd1;
				end else begin
					col_cnt = nxt[WIN_W-1:0];
				end
				results_due.push_back(res);
			end
			OP_FLUSH: begin
				if (dirty) begin
					res.k = KIND_DIRTY_RECT;
					res.left = box_l;
					res.top = box_t;
					res.right = box_r;
					res.bottom = box_b;
					dirty = 1'b0;
				end else begin
					res.k = KIND_NOTHING_DIRTY;
				end
				col_cnt = '0;
				row_cnt = '0;
				results_due.push_back(res);
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		writer_result_t want;
		if (!arst_n) begin
			frame_w = RESET_WIDTH;
			frame_h = RESET_HEIGHT;
			org_x = '0;
			org_y = '0;
			span = '0;
			col_cnt = '0;
			row_cnt = '0;
			dirty = 1'b0;
			box_l = '0;
			box_t = '0;
			box_r = '0;
			box_b = '0;
			results_due.delete();
			failures = 0;
			pending = 0;
		end else begin
			if (write_en)
				take_register(write_index, write_data);
			if (out_valid && !out_stall) begin
				if (results_due.size() == 0) begin
					flag_mismatch($sformatf("result of kind %0d with nothing outstanding", kind));
				end else begin
					want = results_due.pop_front();
					check_field("kind", 32'(kind), 32'(want.k));
					check_field("write_x", 32'(write_x), 32'(want.x));
					check_field("write_y", 32'(write_y), 32'(want.y));
					check_field("write_argb", write_argb, want.argb);
					check_field("rect_left", 32'(rect_left), 32'(want.left));
					check_field("rect_top", 32'(rect_top), 32'(want.top));
					check_field("rect_right", 32'(rect_right), 32'(want.right));
					check_field("rect_bottom", 32'(rect_bottom), 32'(want.bottom));
				end
			end
			if (in_valid && !in_stall)
				advance_writer(opcode, window_left, window_top, window_right, pixel_rgb);
			pending = results_due.size();
		end
	end

endmodule

// ===== bench/testbench.sv =====
// Top of the window pixel writer bench: clock, reset, request and stall stimulus,
// register writes and the verdict. Depends on wpw_pkg, the block and wpw_watch.
module testbench;
	import wpw_pkg::*;

	// spare register slots the block has no name for, and the unused opcode
	localparam logic [1:0] REG_SPARE_A = 2'd2;
	localparam logic [1:0] REG_SPARE_B = 2'd3;
	localparam logic [1:0] OP_IGNORED  = 2'd3;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               write_en = 1'b0;
	logic [1:0]         write_index = '0;
	logic [DIM_W-1:0]   write_data = '0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	logic [1:0]         opcode = '0;
	logic [WIN_W-1:0]   window_left = '0;
	logic [WIN_W-1:0]   window_top = '0;
	logic [WIN_W-1:0]   window_right = '0;
	logic [RGB_W-1:0]   pixel_rgb = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	logic [2:0]         kind;
	logic [COORD_W-1:0] write_x, write_y;
	logic [ARGB_W-1:0]  write_argb;
	logic [COORD_W-1:0] rect_left, rect_top, rect_right, rect_bottom;
	int                 failures;
	int                 pending;

	// calm = 1 turns off idling on both sides
	logic calm = 1'b0;
	// frame size as last written, clamped, used to aim the windows and to rewrite the width
	int shape_w = 480;
	int shape_h = 272;

	window_pixel_writer_dirty_rect u_dut (
		.clk(clk), .arst_n(arst_n),
		.write_en(write_en), .write_index(write_index), .write_data(write_data),
		.in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
		.window_left(window_left), .window_top(window_top), .window_right(window_right),
		.pixel_rgb(pixel_rgb),
		.out_valid(out_valid), .out_stall(out_stall), .kind(kind),
		.write_x(write_x), .write_y(write_y), .write_argb(write_argb),
		.rect_left(rect_left), .rect_top(rect_top), .rect_right(rect_right),
		.rect_bottom(rect_bottom)
	);

	wpw_watch u_watch (
		.clk(clk), .arst_n(arst_n),
		.write_en(write_en), .write_index(write_index), .write_data(write_data),
		.in_valid(in_valid), .in_stall(in_stall), .opcode(opcode),
		.window_left(window_left), .window_top(window_top), .window_right(window_right),
		.pixel_rgb(pixel_rgb),
		.out_valid(out_valid), .out_stall(out_stall), .kind(kind),
		.write_x(write_x), .write_y(write_y), .write_argb(write_argb),
		.rect_left(rect_left), .rect_top(rect_top), .rect_right(rect_right),
		.rect_bottom(rect_bottom),
		.failures(failures), .pending(pending)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Stall the result side at random, with odds of 31 in 100, unless calm.
	always @(negedge clk) begin
		out_stall <= !calm && ($urandom_range(99) < 31);
	end

	// Hand one request to the block. Entered and left at a falling edge; the
	// payload holds until the rising edge that accepts it.
	task automatic send_request(input logic [1:0] op, input logic [WIN_W-1:0] l,
			input logic [WIN_W-1:0] t, input logic [WIN_W-1:0] r, input logic [RGB_W-1:0] rgb);
		while (!calm && $urandom_range(99) < 31) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		window_left <= l;
		window_top <= t;
		window_right <= r;
		pixel_rgb <= rgb;
		do
			@(posedge clk);
		while (in_stall);
		@(negedge clk);
	endtask

	// A pixel ignores the window fields, so fill them with noise.
	task automatic push_pixel();
		send_request(OP_PUSH_PIXEL, WIN_W'($urandom), WIN_W'($urandom), WIN_W'($urandom),
			RGB_W'($urandom));
	endtask

	task automatic flush_box();
		send_request(OP_FLUSH, WIN_W'($urandom), WIN_W'($urandom), WIN_W'($urandom),
			RGB_W'($urandom));
	endtask

	// Drop valid, wait for every outstanding result, then keep idling so the
	// two pipeline stages are clear before touching registers.
	task automatic drain();
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [DIM_W-1:0] data);
		write_en <= 1'b1;
		write_index <= idx;
		write_data <= data;
		@(negedge clk);
		write_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		write_reg(REG_FRAME_WIDTH, w);
		write_reg(REG_FRAME_HEIGHT, h);
		shape_w = (w < MIN_WIDTH) ? MIN_WIDTH : ((w > 4096) ? 4096 : w);
		shape_h = (h < MIN_HEIGHT) ? MIN_HEIGHT : ((h > 4096) ? 4096 : h);
	endtask

	// Frame sizes: zero, all-ones, values at and beyond the clamp edges, or random from 120 to 4096.
	function automatic logic [DIM_W-1:0] pick_dim();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			2: return 13'd4096;
			3: return 13'd4097;
			4: return 13'd159;
			5: return 13'd119;
			default: return DIM_W'($urandom_range(120, 4096));
		endcase
	endfunction

	initial begin : stimulus
		int sent, run, span_len, roll, phase;
		logic [WIN_W-1:0] l, t;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part at the reset frame of 480x272.
		flush_box();                                   // nothing dirty yet
		send_request(OP_PUSH_PIXEL, '0, '0, '0, '0);   // reset window: 65536 wide
		send_request(OP_PUSH_PIXEL, '1, '1, '1, '1);
		flush_box();
		// narrow window across the right frame edge, near the bottom, wrapping once
		send_request(OP_SET_WINDOW, 16'd478, 16'd270, 16'd481, '0);
		repeat (5) push_pixel();
		// right one short of left: width wraps to zero, i.e. 65536 columns
		send_request(OP_SET_WINDOW, 16'hFFFF, 16'hFFFF, 16'hFFFE, '0);
		push_pixel();
		send_request(OP_IGNORED, '1, '1, '1, '1);
		// right below left: a very wide window
		send_request(OP_SET_WINDOW, 16'd10, 16'd5, 16'd3, '1);
		push_pixel();
		flush_box();
		push_pixel();
		drain();

		// Same size again keeps the box; spare indexes are ignored.
		write_reg(REG_FRAME_WIDTH, 13'd480);
		write_reg(REG_SPARE_A, '1);
		write_reg(REG_SPARE_B, '0);
		flush_box();
		push_pixel();
		drain();
		// A real size change clears the box: clamp up to 160, down to 4096.
		set_frame('0, '1);
		flush_box();
		send_request(OP_SET_WINDOW, 16'd159, 16'd4095, 16'd160, '0);
		push_pixel();
		push_pixel();
		flush_box();
		drain();
		set_frame(13'd4097, '0);
		send_request(OP_SET_WINDOW, 16'd4095, 16'd119, 16'd4095, '0);
		push_pixel();
		flush_box();
		drain();

		// Long calm stretch: walk a one-column window down past the frame
		// bottom, then run a 65536-wide window along one row.
		calm <= 1'b1;
		send_request(OP_SET_WINDOW, 16'd7, '0, 16'd7, '0);
		repeat (200) push_pixel();
		flush_box();
		send_request(OP_SET_WINDOW, '0, 16'd3, 16'hFFFF, '0);
		repeat (200) push_pixel();
		flush_box();
		drain();
		calm <= 1'b0;

		// Random phases, each under a fresh frame size.
		for (phase = 0; phase < 8; phase++) begin
			set_frame(pick_dim(), pick_dim());
			if ($urandom_range(1))
				write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, DIM_W'($urandom));
			if ($urandom_range(3) == 0)
				write_reg(REG_FRAME_WIDTH, DIM_W'(shape_w));   // rewrite, no change
			sent = 0;
			while (sent < 170) begin
				roll = $urandom_range(99);
				if (roll < 75) begin
					// aim a small window at the frame, fill a few rows, maybe flush
					span_len = $urandom_range(1, 40);
					l = WIN_W'($urandom_range(0, shape_w + 8));
					t = WIN_W'($urandom_range(0, shape_h + 4));
					send_request(OP_SET_WINDOW, l, t, WIN_W'(l + span_len - 1),
						RGB_W'($urandom));
					run = $urandom_range(1, 3 * span_len + 4);
					repeat (run) push_pixel();
					sent += run + 1;
					if ($urandom_range(9) < 6) begin
						flush_box();
						sent++;
					end
				end else if (roll < 85) begin
					flush_box();
					sent++;
				end else if (roll < 93) begin
					// any window at all, mostly far outside the frame
					send_request(OP_SET_WINDOW, WIN_W'($urandom), WIN_W'($urandom),
						WIN_W'($urandom), RGB_W'($urandom));
					run = $urandom_range(1, 6);
					repeat (run) push_pixel();
					sent += run + 1;
				end else begin
					send_request(OP_IGNORED, WIN_W'($urandom), WIN_W'($urandom),
						WIN_W'($urandom), RGB_W'($urandom));
					push_pixel();
					sent++;
				end
			end
			drain();
		end

		repeat (8) @(negedge clk);
		if (failures == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// Hard stop, several times the slowest clean run.
	initial begin
		#1000000;
		$display("status: fail");
		$finish;
	end

endmodule
